[hw/rtl/button_debounce_press_classifier_top_defines.svh]
// Assertion macros for the button debounce / press classifier.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BDPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDPC_ASSERT(lbl, prop, msg)
`define BDPC_ASSERT_IMP(lbl, ante, cons, msg)
`define BDPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/bdpc_pkg.sv]
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int unsigned TIME_BITS_DEF = 16;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUICK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL   = 3'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd2000;
  localparam logic [CFG_W-1:0] QUICK_RST    = 16'd100;
  localparam logic [CFG_W-1:0] NORMAL_RST   = 16'd500;

  localparam logic [1:0] BS_IDLE     = 2'd0;
  localparam logic [1:0] BS_PRESSED  = 2'd1;
  localparam logic [1:0] BS_HELD     = 2'd2;
  localparam logic [1:0] BS_RELEASED = 2'd3;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_QUICK  = 3'd1;
  localparam logic [2:0] EV_NORMAL = 3'd2;
  localparam logic [2:0] EV_MEDIUM = 3'd3;
  localparam logic [2:0] EV_LONG   = 3'd4;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] quick_limit_ms;
    logic [CFG_W-1:0] normal_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
  } in_t;

  typedef struct packed {
    logic [1:0]  button_state;
    logic [2:0]  press_event;
    logic        debounced_pressed;
    logic [7:0]  presses_seen;
    logic [15:0] press_length;
  } out_t;

endpackage

[hw/rtl/bdpc_stream_if.sv]
`timescale 1ns / 1ps

interface bdpc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/button_debounce_press_classifier_top.sv]
`timescale 1ns / 1ps
// Button debouncer and press classifier. Each request on in_i is one
// millisecond tick with the raw active-low pin; each produces exactly one
// request on out_o with the FSM state, the press event (nonzero only on
// the tick that enters released), the debounced level, the press count
// and the length of the last press. One request is taken every cycle
// while out_o does not stall; each tick passes from the input register
// through the state update into the output register.
// The output register lets a new tick be taken while a result waits.
// Configuration writes are meant for idle periods only.

`include "button_debounce_press_classifier_top_defines.svh"

module button_debounce_press_classifier_top
  import bdpc_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  bdpc_stream_if.sink          in_i,
  bdpc_stream_if.source        out_o
);

  cfg_t cfg_q;
  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;
  logic advance;
  logic stable;
  out_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DEBOUNCE_RST;
      cfg_q.long_press_ms   <= LONG_RST;
      cfg_q.quick_limit_ms  <= QUICK_RST;
      cfg_q.normal_limit_ms <= NORMAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_wdata_i;
        CFG_LONG:     cfg_q.long_press_ms   <= cfg_wdata_i;
        CFG_QUICK:    cfg_q.quick_limit_ms  <= cfg_wdata_i;
        CFG_NORMAL:   cfg_q.normal_limit_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.payload;
    end
  end

  bdpc_debounce #(
    .TIME_BITS(TIME_BITS)
  ) u_debounce (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .pin_level_i  (in_q.pin_level),
    .debounce_ms_i(cfg_q.debounce_ms),
    .stable_o     (stable)
  );

  bdpc_press_fsm #(
    .TIME_BITS(TIME_BITS)
  ) u_press_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .stable_i(stable),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `BDPC_ASSERT_IMP(a_event_only_released, out_valid_q && (out_q.press_event != EV_NONE), out_q.button_state == BS_RELEASED, "press event outside released state")
  `BDPC_ASSERT_IMP(a_released_has_event, out_valid_q && (out_q.button_state == BS_RELEASED), out_q.press_event != EV_NONE, "released state without press event")
  `BDPC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "computed result not registered")
  `BDPC_ASSERT_NEXT(a_stall_keeps_input, in_valid_q && !advance, in_valid_q && $stable(in_q), "pending tick lost during stall")

endmodule

[hw/rtl/bdpc_debounce.sv]
`timescale 1ns / 1ps

module bdpc_debounce
  import bdpc_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             pin_level_i,
  input  logic [CFG_W-1:0] debounce_ms_i,
  output logic             stable_o
);

  localparam int unsigned CmpW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic                 raw_q, raw_d;
  logic [TIME_BITS-1:0] steady_q, steady_d;
  logic                 stable_q, stable_d;
  logic                 reading;

  assign reading = ~pin_level_i;

  always_comb begin
    raw_d    = reading;
    steady_d = '0;
    if (reading == raw_q) begin
      steady_d = (steady_q == '1) ? steady_q : TIME_BITS'(steady_q + 1'b1);
    end
    stable_d = stable_q;
    if (CmpW'(steady_d) > CmpW'(debounce_ms_i)) begin
      stable_d = reading;
    end
  end

  assign stable_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      steady_q <= '0;
      stable_q <= 1'b0;
    end else if (en_i) begin
      raw_q    <= raw_d;
      steady_q <= steady_d;
      stable_q <= stable_d;
    end
  end

endmodule

[hw/rtl/bdpc_press_fsm.sv]
`timescale 1ns / 1ps

module bdpc_press_fsm
  import bdpc_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic stable_i,
  input  cfg_t cfg_i,
  output out_t result_o
);

  localparam int unsigned CmpW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_PRESSED  = 4'b0010,
    ST_HELD     = 4'b0100,
    ST_RELEASED = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [TIME_BITS-1:0] since_q, since_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic                 long_q, long_d;
  logic [7:0]           cnt_q, cnt_d;

  always_comb begin
    logic [TIME_BITS-1:0] since_inc;
    logic [CmpW-1:0]      last_ext;
    logic [2:0]           ev;
    logic [1:0]           code;

    since_inc = (since_q == '1) ? since_q : TIME_BITS'(since_q + 1'b1);
    state_d   = state_q;
    since_d   = since_q;
    last_d    = last_q;
    long_d    = long_q;
    cnt_d     = cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (stable_i) begin
          state_d = ST_PRESSED;
          since_d = '0;
          cnt_d   = cnt_q + 8'd1;
        end
      end
      ST_PRESSED: begin
        since_d = since_inc;
        if (!stable_i) begin
          state_d = ST_RELEASED;
          last_d  = since_inc;
        end else if (CmpW'(since_inc) > CmpW'(cfg_i.long_press_ms)) begin
          state_d = ST_HELD;
          long_d  = 1'b1;
        end
      end
      ST_HELD: begin
        since_d = since_inc;
        if (!stable_i) begin
          state_d = ST_RELEASED;
          last_d  = since_inc;
        end
      end
      default: begin
        state_d = ST_IDLE;
        long_d  = 1'b0;
      end
    endcase

    last_ext = CmpW'(last_d);
    ev       = EV_NONE;
    if (state_d == ST_RELEASED) begin
      if (long_d) begin
        ev = EV_LONG;
      end else if (last_ext < CmpW'(cfg_i.quick_limit_ms)) begin
        ev = EV_QUICK;
      end else if (last_ext < CmpW'(cfg_i.normal_limit_ms)) begin
        ev = EV_NORMAL;
      end else begin
        ev = EV_MEDIUM;
      end
    end

    case (state_d)
      ST_PRESSED:  code = BS_PRESSED;
      ST_HELD:     code = BS_HELD;
      ST_RELEASED: code = BS_RELEASED;
      default:     code = BS_IDLE;
    endcase

    result_o.button_state      = code;
    result_o.press_event       = ev;
    result_o.debounced_pressed = stable_i;
    result_o.presses_seen      = cnt_d;
    result_o.press_length      = (last_ext > CmpW'(16'hFFFF)) ? 16'hFFFF : last_ext[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      since_q <= '0;
      last_q  <= '0;
      long_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (en_i) begin
      state_q <= state_d;
      since_q <= since_d;
      last_q  <= last_d;
      long_q  <= long_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[test/tb_button_debounce_press_classifier_top.sv]
`timescale 1ns / 1ps

module tb_button_debounce_press_classifier_top;
  import bdpc_pkg::*;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_NORMAL + 1'b1;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  bdpc_stream_if #(.payload_t(in_t))  tick_if ();
  bdpc_stream_if #(.payload_t(out_t)) report_if ();

  button_debounce_press_classifier_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (tick_if),
    .out_o      (report_if)
  );

  // press classifier state and its copy of the registers
  logic [15:0] debounce_lim, long_lim, quick_lim, normal_lim;
  logic        pin_prev, level_db, long_seen;
  logic [15:0] steady_cnt, press_ticks, last_press_len;
  logic [1:0]  fsm;
  logic [7:0]  press_cnt;

  out_t        tick_reports_q[$];
  int unsigned tick_cnt, report_cnt, bad_cnt, release_cnt;
  int unsigned burst_left;
  rx_mode_e    rx_mode;
  int unsigned rx_left, rx_cnt;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic clear_model();
    debounce_lim   = DEBOUNCE_RST;
    long_lim       = LONG_RST;
    quick_lim      = QUICK_RST;
    normal_lim     = NORMAL_RST;
    pin_prev       = 1'b0;
    level_db       = 1'b0;
    long_seen      = 1'b0;
    steady_cnt     = '0;
    press_ticks    = '0;
    last_press_len = '0;
    fsm            = BS_IDLE;
    press_cnt      = '0;
  endtask

  task automatic classify_tick(input logic pin, output out_t res);
    logic       reading;
    logic [2:0] ev;
    reading = ~pin;
    ev      = EV_NONE;
    if (reading != pin_prev) begin
      pin_prev   = reading;
      steady_cnt = '0;
    end else if (steady_cnt != TICK_MAX) begin
      steady_cnt++;
    end
    if (steady_cnt > debounce_lim) level_db = reading;

    case (fsm)
      BS_IDLE: begin
        if (level_db) begin
          fsm         = BS_PRESSED;
          press_ticks = '0;
          press_cnt++;
        end
      end
      BS_PRESSED: begin
        if (press_ticks != TICK_MAX) press_ticks++;
        if (!level_db) begin
          fsm            = BS_RELEASED;
          last_press_len = press_ticks;
        end else if (press_ticks > long_lim) begin
          fsm       = BS_HELD;
          long_seen = 1'b1;
        end
      end
      BS_HELD: begin
        if (press_ticks != TICK_MAX) press_ticks++;
        if (!level_db) begin
          fsm            = BS_RELEASED;
          last_press_len = press_ticks;
        end
      end
      default: begin
        fsm       = BS_IDLE;
        long_seen = 1'b0;
      end
    endcase

    if (fsm == BS_RELEASED) begin
      release_cnt++;
      if (long_seen) ev = EV_LONG;
      else if (last_press_len < quick_lim) ev = EV_QUICK;
      else if (last_press_len < normal_lim) ev = EV_NORMAL;
      else ev = EV_MEDIUM;
    end

    res.button_state      = fsm;
    res.press_event       = ev;
    res.debounced_pressed = level_db;
    res.presses_seen      = press_cnt;
    res.press_length      = last_press_len;
  endtask

  always @(posedge clk_i) begin : check_reports
    out_t want;
    out_t got;
    if (rst_ni) begin
      if (tick_if.valid && tick_if.ready) begin
        classify_tick(tick_if.payload.pin_level, want);
        tick_reports_q.push_back(want);
      end
      if (report_if.valid && report_if.ready) begin
        got = report_if.payload;
        report_cnt++;
        if (tick_reports_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) $display("%0t: result with no tick pending", $realtime);
        end else begin
          want = tick_reports_q.pop_front();
          if (got.button_state !== want.button_state || got.press_event !== want.press_event ||
              got.debounced_pressed !== want.debounced_pressed ||
              got.presses_seen !== want.presses_seen ||
              got.press_length !== want.press_length) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("%0t: result %0d exp state %0d ev %0d lvl %0d cnt %0d len %0d",
                       $realtime, report_cnt, want.button_state, want.press_event,
                       want.debounced_pressed, want.presses_seen, want.press_length);
              $display("%0t: result %0d got state %0d ev %0d lvl %0d cnt %0d len %0d",
                       $realtime, report_cnt, got.button_state, got.press_event,
                       got.debounced_pressed, got.presses_seen, got.press_length);
            end
          end
        end
      end
    end
  end

  // result side stalls on a randomly chosen pattern: steady, random or periodic
  initial begin
    report_if.ready = 1'b0;
    rx_left = 0;
    rx_cnt  = 0;
    forever begin
      @(negedge clk_i);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      rx_cnt++;
      case (rx_mode)
        RX_STEADY: report_if.ready <= 1'b1;
        RX_RANDOM: report_if.ready <= ($urandom_range(0, 3) != 0);
        default:   report_if.ready <= ((rx_cnt % 8) >= 3);
      endcase
    end
  end

  // called at a falling edge, returns at a falling edge once the request is taken
  task automatic push_tick(input logic pin);
    tick_if.valid             <= 1'b1;
    tick_if.payload.pin_level <= pin;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    tick_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
  endtask

  task automatic settle();
    tick_if.valid <= 1'b0;
    while (tick_reports_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_DEBOUNCE: debounce_lim = val;
      CFG_LONG:     long_lim = val;
      CFG_QUICK:    quick_lim = val;
      CFG_NORMAL:   normal_lim = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [15:0] deb, input logic [15:0] lng,
                            input logic [15:0] qck, input logic [15:0] nrm);
    write_cfg(CFG_DEBOUNCE, deb);
    write_cfg(CFG_LONG, lng);
    write_cfg(CFG_QUICK, qck);
    write_cfg(CFG_NORMAL, nrm);
  endtask

  task automatic hold_pin(input logic pin, input int unsigned n);
    repeat (n) push_tick(pin);
  endtask

  task automatic chatter(input int unsigned n);
    repeat (n) push_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic press_once(input int unsigned hold, input int unsigned rest);
    hold_pin(1'b0, hold);
    hold_pin(1'b1, rest);
  endtask

  task automatic test_reset_config();
    hold_pin(1'b1, 2);
    press_once(60, 60);
    settle();
  endtask

  task automatic test_press_kinds();
    set_limits(16'd0, 16'd5, 16'd3, 16'd4);
    hold_pin(1'b1, 1);
    press_once(1, 1);
    press_once(2, 2);
    press_once(3, 2);
    press_once(4, 2);
    press_once(7, 2);
    settle();
  endtask

  task automatic test_limit_extremes();
    set_limits(16'd0, 16'd0, 16'd0, 16'd0);
    press_once(3, 3);
    settle();
    set_limits(16'd0, 16'hFFFF, 16'd0, 16'd0);
    press_once(3, 3);
    settle();
    write_cfg(CFG_QUICK, 16'hFFFF);
    press_once(3, 3);
    settle();
    set_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    press_once(3, 3);
    settle();
    write_cfg(CFG_DEBOUNCE, 16'hFFFF);
    press_once(20, 5);
    settle();
    for (int i = 0; i < 4; i++) write_cfg(CFG_IDX_W'(CFG_FIRST_UNUSED + i), 16'hFFFF);
    write_cfg(CFG_DEBOUNCE, 16'd1);
    press_once(4, 4);
    settle();
  endtask

  task automatic test_count_wrap();
    set_limits(16'd0, 16'd10, 16'd1, 16'd2);
    repeat (260) press_once(2, 2);
    settle();
  endtask

  task automatic test_random_presses();
    int unsigned start;
    int unsigned deb, lng;
    for (int phase = 0; phase < 2; phase++) begin
      deb = $urandom_range(0, 6);
      lng = $urandom_range(0, 40);
      set_limits(16'(deb), 16'(lng), 16'($urandom_range(0, 12)), 16'($urandom_range(0, 24)));
      start = tick_cnt;
      while (tick_cnt - start < 45) begin
        if ($urandom_range(0, 6) == 0) begin
          chatter($urandom_range(1, 8));
        end else begin
          if ($urandom_range(0, 1)) chatter($urandom_range(1, 4));
          hold_pin(1'b0, deb + $urandom_range(0, lng + 8));
          if ($urandom_range(0, 1)) chatter($urandom_range(1, 4));
          hold_pin(1'b1, deb + $urandom_range(1, 6));
        end
      end
      settle();
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni                    = 1'b0;
    cfg_we_i                  = 1'b0;
    cfg_idx_i                 = CFG_DEBOUNCE;
    cfg_wdata_i               = '0;
    tick_if.valid             = 1'b0;
    tick_if.payload.pin_level = 1'b1;
    tick_cnt    = 0;
    report_cnt  = 0;
    bad_cnt     = 0;
    release_cnt = 0;
    burst_left  = 0;
    clear_model();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_press_kinds();
    test_limit_extremes();
    test_count_wrap();
    test_random_presses();

    tick_if.valid <= 1'b0;
    waited = 0;
    while (tick_reports_q.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (5) @(posedge clk_i);

    $display("ran %0d ticks through reset, directed and random limit settings", tick_cnt);
    $display("checked %0d results, %0d of them releases", report_cnt, release_cnt);
    if (bad_cnt == 0 && tick_reports_q.size() == 0) begin
      $display("tb_button_debounce_press_classifier_top passed");
    end else begin
      $display("%0d mismatches, %0d results missing", bad_cnt, tick_reports_q.size());
      $display("tb_button_debounce_press_classifier_top failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout after %0d ticks", tick_cnt);
    $display("tb_button_debounce_press_classifier_top failed");
    $finish;
  end

endmodule
